### sv/assert_macros.svh
// Assertion macros used by the symbol stack datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SSS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define SSS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define SSS_ASSERT(lbl, clk, rst_n, prop)
`define SSS_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### sv/sss_pkg.sv
// Types and codes for the scoped symbol stack.
package sss_pkg;

	typedef enum logic [1:0] {
		OP_BEGIN  = 2'd0,
		OP_END    = 2'd1,
		OP_ADD    = 2'd2,
		OP_LOOKUP = 2'd3
	} sss_op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_SCOPE    = 3'd4
	} sss_status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_RESP
	} sss_state_t;

	typedef struct packed {
		sss_op_t     req_type;
		logic [31:0] name_key;
		logic [31:0] entry_data;
	} sss_req_t;

	typedef struct packed {
		sss_status_t status;
		logic [31:0] found_data;
		logic [5:0]  found_index;
		logic [7:0]  current_depth;
		logic [6:0]  entry_count;
	} sss_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic scan;
		logic finish;
	} sss_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic needs_scan;
		logic scan_done;
	} sss_stat_t;

endpackage

### sv/scoped_symbol_stack.sv
// Top level of the scoped symbol stack: sequencer plus datapath.
//
//   Port group      | Dir | Handshake                      | Word
//   ----------------+-----+--------------------------------+-----------
//   start/busy/req  | in  | taken when start && !busy      | sss_req_t
//   done/rsp        | out | one-cycle strobe, always taken | sss_rsp_t
//
// Begin scope and errored end scope skip the walk and go straight to respond.
// Add, lookup and end scope walk the entry memory top down, one entry per
// cycle through its single registered read port.
// busy stays high from accept until done; the next word may start with done.
// Reset clears the depth and the entry count; the memory needs no clearing.
// The receiver cannot stall: done flags each result for exactly one cycle.
module scoped_symbol_stack import sss_pkg::*; #(
	parameter int ENTRIES   = 64,
	parameter int KEY_BITS  = 32,
	parameter int DATA_BITS = 32,
	parameter int MAX_SCOPE = 255
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  sss_req_t req,
	output logic     done,
	output sss_rsp_t rsp
);

	sss_cmd_t  cmd;
	sss_stat_t stat;

	sss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	sss_datapath #(
		.ENTRIES   (ENTRIES),
		.KEY_BITS  (KEY_BITS),
		.DATA_BITS (DATA_BITS),
		.MAX_SCOPE (MAX_SCOPE)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

### sv/sss_ctrl.sv
// Request sequencer: accept, walk the stack, respond.
module sss_ctrl import sss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  sss_stat_t stat,
	output sss_cmd_t  cmd,
	output logic      busy
);

	sss_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			FSM_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = stat.needs_scan ? FSM_SCAN : FSM_RESP;
				end
			end
			FSM_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = FSM_RESP;
				end
			end
			FSM_RESP: begin
				cmd.finish = 1'b1;
				state_d    = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

endmodule

### sv/sss_datapath.sv
// Entry memory, scan pointer, depth and count registers, result register.
`include "assert_macros.svh"
module sss_datapath import sss_pkg::*; #(
	parameter int ENTRIES   = 64,
	parameter int KEY_BITS  = 32,
	parameter int DATA_BITS = 32,
	parameter int MAX_SCOPE = 255
) (
	input  logic      clk,
	input  logic      arst_n,
	input  sss_req_t  req,
	input  sss_cmd_t  cmd,
	output sss_stat_t stat,
	output logic      done,
	output sss_rsp_t  rsp
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int DW = $clog2(MAX_SCOPE + 1);

	logic [KEY_BITS-1:0]  key_mem  [ENTRIES];
	logic [DATA_BITS-1:0] data_mem [ENTRIES];
	logic [DW-1:0]        lvl_mem  [ENTRIES];

	logic [CW-1:0]        count_q;
	logic [DW-1:0]        depth_q;
	logic                 err_q;
	logic                 hit_q;
	logic                 rd_vld_s1;
	sss_op_t              op_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [DATA_BITS-1:0] wdata_q;
	logic [CW-1:0]        ptr_q;
	logic [IW-1:0]        rd_idx_s1;
	logic [KEY_BITS-1:0]  rd_key_s1;
	logic [DATA_BITS-1:0] rd_data_s1;
	logic [DW-1:0]        rd_lvl_s1;
	logic [IW-1:0]        hit_idx_q;
	logic [DATA_BITS-1:0] hit_data_q;

	logic          at_max, at_zero;
	logic          lvl_lt, lvl_gt, key_eq;
	logic          stop, hit_now, issue, pop_now;
	logic [IW-1:0] rd_addr;
	logic          full, add_ok;
	logic [CW-1:0] count_nxt;
	sss_status_t   status_d;
	logic [IW-1:0] idx_d;

	assign at_max  = (depth_q == DW'(MAX_SCOPE));
	assign at_zero = (depth_q == '0);

	always_comb begin
		stat.scan_done = stop || ((ptr_q == '0) && !rd_vld_s1);
		case (req.req_type) inside
			OP_ADD, OP_LOOKUP: stat.needs_scan = 1'b1;
			OP_END:            stat.needs_scan = !at_zero;
			default:           stat.needs_scan = 1'b0;
		endcase
	end

	// evaluate the entry read last cycle while the next one is fetched
	assign lvl_lt = rd_lvl_s1 < depth_q;
	assign lvl_gt = rd_lvl_s1 > depth_q;
	assign key_eq = rd_key_s1 == key_q;

	always_comb begin
		case (op_q)
			OP_ADD:    stop = rd_vld_s1 && (lvl_lt || key_eq);
			OP_LOOKUP: stop = rd_vld_s1 && key_eq;
			OP_END:    stop = rd_vld_s1 && !lvl_gt;
			default:   stop = rd_vld_s1;
		endcase
	end

	assign hit_now = cmd.scan && rd_vld_s1 && key_eq &&
		((op_q == OP_LOOKUP) || ((op_q == OP_ADD) && !lvl_lt));
	assign pop_now = cmd.scan && rd_vld_s1 && (op_q == OP_END) && lvl_gt;
	assign issue   = cmd.scan && !stop && (ptr_q != '0);
	assign rd_addr = IW'(ptr_q - CW'(1));

	assign full      = (count_q == CW'(ENTRIES));
	assign add_ok    = (op_q == OP_ADD) && !hit_q && !full;
	assign count_nxt = add_ok ? count_q + CW'(1) : count_q;

	always_comb begin
		status_d = ST_OK;
		idx_d    = '0;
		case (op_q) inside
			OP_BEGIN, OP_END: begin
				status_d = err_q ? ST_SCOPE : ST_OK;
			end
			OP_ADD: begin
				if (hit_q) begin
					status_d = ST_DUP;
					idx_d    = hit_idx_q;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					idx_d = count_q[IW-1:0];
				end
			end
			default: begin
				status_d = hit_q ? ST_OK : ST_NOTFOUND;
				idx_d    = hit_q ? hit_idx_q : '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			depth_q   <= '0;
			err_q     <= 1'b0;
			hit_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
			done      <= 1'b0;
		end else begin
			done <= cmd.finish;
			if (cmd.accept) begin
				hit_q     <= 1'b0;
				rd_vld_s1 <= 1'b0;
				err_q     <= 1'b0;
				if (req.req_type == OP_BEGIN) begin
					err_q <= at_max;
					if (!at_max) begin
						depth_q <= depth_q + DW'(1);
					end
				end else if (req.req_type == OP_END) begin
					err_q <= at_zero;
					if (!at_zero) begin
						depth_q <= depth_q - DW'(1);
					end
				end
			end
			if (cmd.scan) begin
				rd_vld_s1 <= issue;
			end
			if (hit_now) begin
				hit_q <= 1'b1;
			end
			// drop the entry just read: it lies deeper than the new scope
			if (pop_now) begin
				count_q <= CW'(rd_idx_s1);
			end
			if (cmd.finish) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= req.req_type;
			key_q   <= KEY_BITS'(req.name_key);
			wdata_q <= DATA_BITS'(req.entry_data);
			ptr_q   <= count_q;
		end
		if (issue) begin
			ptr_q      <= ptr_q - CW'(1);
			rd_idx_s1  <= rd_addr;
			rd_key_s1  <= key_mem[rd_addr];
			rd_data_s1 <= data_mem[rd_addr];
			rd_lvl_s1  <= lvl_mem[rd_addr];
		end
		if (hit_now) begin
			hit_idx_q  <= rd_idx_s1;
			hit_data_q <= rd_data_s1;
		end
		if (cmd.finish && add_ok) begin
			key_mem[count_q[IW-1:0]]  <= key_q;
			data_mem[count_q[IW-1:0]] <= wdata_q;
			lvl_mem[count_q[IW-1:0]]  <= depth_q;
		end
		if (cmd.finish) begin
			rsp.status        <= status_d;
			rsp.found_data    <= ((op_q == OP_LOOKUP) && hit_q) ? 32'(hit_data_q) : '0;
			rsp.found_index   <= 6'(idx_d);
			rsp.current_depth <= 8'(depth_q);
			rsp.entry_count   <= 7'(count_nxt);
		end
	end

	`SSS_ASSERT(a_finish_done, clk, arst_n, cmd.finish |=> done)
	`SSS_ASSERT(a_read_below_count, clk, arst_n, rd_vld_s1 |-> (CW'(rd_idx_s1) < count_q))
	`SSS_ASSERT(a_depth_on_accept, clk, arst_n, !cmd.accept |=> $stable(depth_q))
	`SSS_ASSERT_NEVER(a_read_outside_scan, clk, arst_n, rd_vld_s1 && !cmd.scan)

endmodule
